/* rtl/olst_pkg.sv */
package olst_pkg;

  localparam int DEPTH_DEF = 64;
  // wide enough for any position or count up to the largest supported depth
  localparam int POS_W     = 11;
  localparam int COORD_W   = 16;
  localparam int KEY_W     = 2 * COORD_W;
  localparam int IDX_W     = 6;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_READ       = 3'd2,
    OP_WRITE      = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_CONTAINS   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } state_t;

  // broadcast from the controller to every cell of the row
  typedef struct packed {
    logic             cap;
    logic [KEY_W-1:0] cap_key;
    logic [POS_W-1:0] cap_idx;
    logic             apply;
    op_t              op;
    logic             full;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] cnt;
  } cell_ctl_t;

endpackage

/* rtl/ordered_coordinate_list.sv */
// The result is registered on the apply edge, which follows the input capture edge.
// No new item is taken until the current one is applied; the cell row compares every
//   entry on the capture edge and shifts or loads on the apply edge.
// A held result stalls the apply step until the output transfer is taken.
// Reset clears the entry count and handshake state; entry contents are
//   undefined until written.
module ordered_coordinate_list import olst_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_opcode,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic [IDX_W-1:0]          in_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic                      out_found,
  output logic [CNT_OUT_W-1:0]      out_count,
  output logic [1:0]                out_status
);

  localparam int CW = $clog2(DEPTH + 1);

  state_t           state_r, state_nxt;
  op_t              op_r;
  logic [KEY_W-1:0] key_r;
  logic [IDX_W-1:0] idx_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r;
  logic                      out_found_r;
  logic [CNT_OUT_W-1:0]      out_count_r;
  status_t                   out_status_r;

  logic                      in_xfer, apply_go, full, idx_ok;
  logic signed [COORD_W-1:0] res_x, res_y;
  logic                      res_found;
  status_t                   res_status;
  logic [POS_W-1:0]          cnt_wide;
  cell_ctl_t                 ctl;

  logic [KEY_W-1:0] cell_data [DEPTH];
  logic             hit_chain [DEPTH+1];
  logic [KEY_W-1:0] rd_chain  [DEPTH+1];

  assign in_stall = (state_r == ST_APPLY);
  assign in_xfer  = in_valid && !in_stall;
  assign apply_go = (state_r == ST_APPLY) && !(out_valid_r && out_stall);
  assign full     = (cnt_r == CW'(DEPTH));
  assign idx_ok   = ctl.idx < ctl.cnt;

  always_comb begin
    ctl.cap     = in_xfer;
    ctl.cap_key = {in_coord_x, in_coord_y};
    ctl.cap_idx = POS_W'(in_index);
    ctl.apply   = apply_go;
    ctl.op      = op_r;
    ctl.full    = full;
    ctl.key     = key_r;
    ctl.idx     = POS_W'(idx_r);
    ctl.cnt     = POS_W'(cnt_r);
  end

  assign hit_chain[0] = 1'b0;
  assign rd_chain[0]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = key_r;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end
    olst_cell #(.POS(i)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .hit_in     (hit_chain[i]),
      .rd_in      (rd_chain[i]),
      .data       (cell_data[i]),
      .hit_out    (hit_chain[i+1]),
      .rd_out     (rd_chain[i+1])
    );
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    res_x      = '0;
    res_y      = '0;
    res_found  = 1'b0;
    res_status = STS_OK;
    unique case (op_r)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) res_status = STS_FULL;
        else      cnt_nxt = CW'(cnt_r + 1'b1);
      end
      OP_READ: begin
        if (cnt_r == '0) begin
          res_x      = '1;
          res_y      = '1;
          res_status = STS_EMPTY;
        end else if (!idx_ok) begin
          res_x      = '1;
          res_y      = '1;
          res_status = STS_RANGE;
        end else begin
          res_x = rd_chain[DEPTH][KEY_W-1:COORD_W];
          res_y = rd_chain[DEPTH][COORD_W-1:0];
        end
      end
      OP_WRITE: begin
        if (!idx_ok) res_status = STS_RANGE;
      end
      OP_REMOVE: begin
        if (hit_chain[DEPTH]) begin
          cnt_nxt   = CW'(cnt_r - 1'b1);
          res_found = 1'b1;
        end
      end
      OP_CONTAINS: res_found = hit_chain[DEPTH];
      default: cnt_nxt = cnt_r;
    endcase
  end

  assign cnt_wide = POS_W'(cnt_nxt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_APPLY;
      ST_APPLY: if (apply_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply_go) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= op_t'(in_opcode);
      key_r <= {in_coord_x, in_coord_y};
      idx_r <= in_index;
    end
    if (apply_go) begin
      out_x_r      <= res_x;
      out_y_r      <= res_y;
      out_found_r  <= res_found;
      out_count_r  <= cnt_wide[CNT_OUT_W-1:0];
      out_status_r <= res_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_found  = out_found_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_cnt_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (cnt_r != $past(cnt_r)) |-> $past(apply_go))
    else $error("entry count moved outside an apply step");

  a_result_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == ST_APPLY))
    else $error("result raised without an apply step");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> out_status_r == STS_OK)
    else $error("found flag with error status");

endmodule

/* rtl/olst_cell.sv */
module olst_cell import olst_pkg::*; #(
  parameter int POS = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [KEY_W-1:0] left_data,
  input  logic [KEY_W-1:0] right_data,
  input  logic             hit_in,
  input  logic [KEY_W-1:0] rd_in,
  output logic [KEY_W-1:0] data,
  output logic             hit_out,
  output logic [KEY_W-1:0] rd_out
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

  logic [KEY_W-1:0] data_r, data_nxt;
  logic [KEY_W-1:0] rd_r;
  logic             match_r;

  assign data = data_r;
  // first-match prefix and read-out both ripple along the row
  assign hit_out = hit_in | match_r;
  assign rd_out  = rd_in | rd_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.apply) begin
      unique case (ctl.op)
        OP_PUSH_FRONT: begin
          if (!ctl.full) data_nxt = left_data;
        end
        OP_PUSH_BACK: begin
          if (!ctl.full && MY_POS == ctl.cnt) data_nxt = ctl.key;
        end
        OP_WRITE: begin
          if (MY_POS == ctl.idx && ctl.idx < ctl.cnt) data_nxt = ctl.key;
        end
        OP_REMOVE: begin
          // everything from the first match onwards closes up by one
          if (hit_out) data_nxt = right_data;
        end
        default: data_nxt = data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctl.cap) begin
      match_r <= (MY_POS < ctl.cnt) && (data_r == ctl.cap_key);
      rd_r    <= (MY_POS == ctl.cap_idx) ? data_r : '0;
    end
  end

endmodule
